@@ src/icf_pkg.sv @@
package icf_pkg;

    typedef enum logic [2:0] {
        K_SMOOTH  = 3'd0,
        K_BLUR    = 3'd1,
        K_MEAN    = 3'd2,
        K_EMBOSS  = 3'd3,
        K_SHARPEN = 3'd4
    } t_kernel;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_KERNEL = 2'd2;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    localparam int SUM_W = 14;
    localparam int DIV_W = 13;

    // reciprocals scaled by 2^16, exact for sums below 2^13
    localparam logic [15:0] RECIP9 = 16'd7282;
    localparam logic [15:0] RECIP3 = 16'd21846;

    typedef logic [7:0] t_chan;
    typedef logic [23:0] t_pix;

    typedef struct packed {
        logic  vld;
        logic  kind;
        logic  emit;
        logic  pass;
        logic  sel_up;
        logic  last;
        logic [2:0] kern;
    } t_s1_ctl;

endpackage

@@ src/icf_in_if.sv @@
interface icf_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;

    modport source (output valid, kind, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, kind, red_in, green_in, blue_in, output ready);
endinterface

@@ src/icf_out_if.sv @@
interface icf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_last;

    modport source (output valid, red_out, green_out, blue_out, frame_last, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, frame_last, output ready);
endinterface

@@ src/icf_linebuf.sv @@
module icf_linebuf #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                         i_clk,
    input  logic                         i_rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_rd_addr,
    input  logic                         i_wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_wr_addr,
    input  icf_pkg::t_pix                i_wr_up,
    input  icf_pkg::t_pix                i_wr_mid,
    output icf_pkg::t_pix                o_rd_up,
    output icf_pkg::t_pix                o_rd_mid
);
    import icf_pkg::*;

    t_pix r_upper [MAX_WIDTH];
    t_pix r_middle [MAX_WIDTH];
    t_pix r_rd_up;
    t_pix r_rd_mid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_upper[i_wr_addr]  <= i_wr_up;
            r_middle[i_wr_addr] <= i_wr_mid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_up  <= r_upper[i_rd_addr];
            r_rd_mid <= r_middle[i_rd_addr];
        end
    end

    assign o_rd_up  = r_rd_up;
    assign o_rd_mid = r_rd_mid;
endmodule

@@ src/icf_lane.sv @@
module icf_lane (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  icf_pkg::t_chan       i_px [9],
    input  logic [2:0]           i_kern,
    output icf_pkg::t_chan       o_q
);
    import icf_pkg::*;

    logic signed [SUM_W-1:0] n_sum;
    logic signed [SUM_W-1:0] r_sum;
    logic [2:0]              r_kern;
    logic signed [SUM_W-1:0] p [9];
    logic [DIV_W-1:0]        s;
    logic [DIV_W+15:0]       prod;
    logic [DIV_W-1:0]        q;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            p[k] = SUM_W'($signed({1'b0, i_px[k]}));
        end
        unique case (t_kernel'(i_kern))
            K_SMOOTH:  n_sum = p[0] + p[1] + p[2] + p[3] + p[4] + p[5] + p[6] + p[7] + p[8];
            K_BLUR:    n_sum = p[0] + p[2] + p[6] + p[8]
                             + ((p[1] + p[3] + p[5] + p[7]) <<< 1) + (p[4] <<< 2);
            K_MEAN:    n_sum = (p[4] <<< 3) + p[4]
                             - (p[0] + p[1] + p[2] + p[3] + p[5] + p[6] + p[7] + p[8]);
            K_EMBOSS:  n_sum = p[1] - p[7];
            K_SHARPEN: n_sum = (p[4] <<< 3) + (p[4] <<< 1) + p[4]
                             - ((p[1] + p[3] + p[5] + p[7]) <<< 1);
            default:   n_sum = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum  <= n_sum;
            r_kern <= i_kern;
        end
    end

    // divide by the kernel divisor, truncating, then clamp
    always_comb begin
        s    = r_sum[DIV_W-1:0];
        prod = '0;
        unique case (t_kernel'(r_kern))
            K_SMOOTH: begin
                prod = s * RECIP9;
                q    = prod[DIV_W+15:16];
            end
            K_SHARPEN: begin
                prod = s * RECIP3;
                q    = prod[DIV_W+15:16];
            end
            K_BLUR:  q = s >> 4;
            default: q = s;
        endcase
        if (r_sum <= 0) begin
            o_q = '0;
        end else if (q > DIV_W'(255)) begin
            o_q = 8'hFF;
        end else begin
            o_q = q[7:0];
        end
    end
endmodule

@@ src/image_conv3x3_filter_top.sv @@
// results pass via s1, s2, s3 to the output register; throughput, while the skid is empty, is
// one request per cycle, set by the single read/write port pair of the line buffers
// a pixel request yields its result once width+1 later pixels have arrived
// reset (synchronous, active low) clears positions, window and pipeline valids;
// line buffer contents stay undefined until written
module image_conv3x3_filter_top #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    icf_in_if.sink       i_pix,
    icf_out_if.source    o_pix,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [15:0]  i_cfg_data
);
    import icf_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int PW = $clog2(MAX_WIDTH + 2);

    logic [11:0]   r_fw;
    logic [15:0]   r_fh;
    logic [2:0]    r_kern;
    logic [CW-1:0] r_in_col, r_out_col;
    logic [15:0]   r_in_row, r_out_row;
    logic [PW-1:0] r_pend;

    logic [WW-1:0] w;
    logic [15:0]   h;
    logic          en, acc, border, is_last, pend_full, s0_emit;
    logic [CW-1:0] rd_addr;
    logic          in_col_wrap, out_col_wrap, in_row_wrap, out_row_wrap;

    t_s1_ctl       r_s1;
    logic [CW-1:0] r_s1_addr;
    t_pix          r_s1_pix;
    logic          r_fw_hit;
    t_pix          r_fw_up, r_fw_mid;
    t_pix          lb_up, lb_mid, u, m;
    logic          wr_hit;

    t_pix          r_win [9];

    logic          r_s2_vld, r_s2_pass, r_s2_last;
    logic [2:0]    r_s2_kern;
    t_pix          r_s2_pix;
    logic          r_s3_vld, r_s3_pass, r_s3_last;
    t_pix          r_s3_pix;

    t_chan         lane_px [3][9];
    t_chan         lane_q [3];
    t_pix          p_pix;

    logic          r_ov, r_sv;
    t_pix          r_o_pix, r_sk_pix;
    logic          r_o_last, r_sk_last;

    always_comb begin
        if (r_fw < 12'd3) begin
            w = WW'(3);
        end else if (32'(r_fw) > MAX_WIDTH) begin
            w = WW'(MAX_WIDTH);
        end else begin
            w = WW'(r_fw);
        end
        h = (r_fh < 16'd3) ? 16'd3 : r_fh;
    end

    assign en          = !r_sv;
    assign i_pix.ready = en;
    assign acc         = i_pix.valid && en;

    always_comb begin
        border = (r_out_row == 16'd0) || (r_out_row == h - 16'd1) || (r_out_col == '0)
              || (32'(r_out_col) + 32'd1 == 32'(w));
        is_last      = (r_out_row == h - 16'd1) && (32'(r_out_col) + 32'd1 == 32'(w));
        pend_full    = (32'(r_pend) == 32'(w) + 32'd1);
        s0_emit      = (i_pix.kind == KIND_DRAIN) ? (r_pend != '0 && border) : pend_full;
        rd_addr      = (i_pix.kind == KIND_DRAIN) ? r_out_col : r_in_col;
        in_col_wrap  = (32'(r_in_col) + 32'd1 >= 32'(w));
        out_col_wrap = (32'(r_out_col) + 32'd1 >= 32'(w));
        in_row_wrap  = ({1'b0, r_in_row} + 17'd1 >= {1'b0, h});
        out_row_wrap = ({1'b0, r_out_row} + 17'd1 >= {1'b0, h});
    end

    // positions, pending count and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw      <= 12'd640;
            r_fh      <= 16'd480;
            r_kern    <= 3'(K_SMOOTH);
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_pend    <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_WIDTH || i_cfg_idx == CFG_HEIGHT) begin
                if (i_cfg_idx == CFG_WIDTH) begin
                    r_fw <= i_cfg_data[11:0];
                end else begin
                    r_fh <= i_cfg_data;
                end
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
                r_pend    <= '0;
            end else if (i_cfg_idx == CFG_KERNEL) begin
                r_kern <= i_cfg_data[2:0];
            end
        end else if (acc) begin
            if (i_pix.kind == KIND_PIXEL) begin
                r_in_col <= in_col_wrap ? '0 : r_in_col + CW'(1);
                if (in_col_wrap) begin
                    r_in_row <= in_row_wrap ? 16'd0 : r_in_row + 16'd1;
                end
                if (!pend_full) begin
                    r_pend <= r_pend + PW'(1);
                end
            end else if (s0_emit) begin
                r_pend <= r_pend - PW'(1);
            end
            if (s0_emit) begin
                r_out_col <= out_col_wrap ? '0 : r_out_col + CW'(1);
                if (out_col_wrap) begin
                    r_out_row <= out_row_wrap ? 16'd0 : r_out_row + 16'd1;
                end
            end
        end
    end

    icf_linebuf #(.MAX_WIDTH(MAX_WIDTH)) u_linebuf (
        .i_clk     (i_clk),
        .i_rd_en   (acc),
        .i_rd_addr (rd_addr),
        .i_wr_en   (en && r_s1.vld && r_s1.kind == KIND_PIXEL),
        .i_wr_addr (r_s1_addr),
        .i_wr_up   (m),
        .i_wr_mid  (r_s1_pix),
        .o_rd_up   (lb_up),
        .o_rd_mid  (lb_mid)
    );

    // a drain may read the column the previous pixel is writing this cycle
    assign wr_hit = r_s1.vld && r_s1.kind == KIND_PIXEL && r_s1_addr == rd_addr;
    assign u      = r_fw_hit ? r_fw_up : lb_up;
    assign m      = r_fw_hit ? r_fw_mid : lb_mid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1     <= '0;
            r_fw_hit <= 1'b0;
        end else if (en) begin
            r_s1.vld    <= acc;
            r_s1.kind   <= i_pix.kind;
            r_s1.emit   <= s0_emit;
            r_s1.pass   <= (i_pix.kind == KIND_DRAIN) || border || (r_kern > 3'(K_SHARPEN));
            r_s1.sel_up <= (32'(r_pend) > 32'(w));
            r_s1.last   <= is_last;
            r_s1.kern   <= r_kern;
            r_fw_hit    <= acc && wr_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_addr <= rd_addr;
            r_s1_pix  <= {i_pix.red_in, i_pix.green_in, i_pix.blue_in};
            r_fw_up   <= m;
            r_fw_mid  <= r_s1_pix;
        end
    end

    // 3x3 window, rightmost column takes upper, middle and new pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
        end else if (en && r_s1.vld && r_s1.kind == KIND_PIXEL) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r*3]   <= r_win[r*3+1];
                r_win[r*3+1] <= r_win[r*3+2];
            end
            r_win[2] <= u;
            r_win[5] <= m;
            r_win[8] <= r_s1_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else if (en) begin
            r_s2_vld <= r_s1.vld && r_s1.emit;
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_pass <= r_s1.pass;
            r_s2_last <= r_s1.last;
            r_s2_kern <= r_s1.kern;
            if (r_s1.kind == KIND_DRAIN) begin
                r_s2_pix <= r_s1.sel_up ? u : m;
            end else begin
                r_s2_pix <= r_win[5];
            end
            r_s3_pass <= r_s2_pass;
            r_s3_last <= r_s2_last;
            r_s3_pix  <= r_s2_pix;
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            for (int k = 0; k < 9; k++) begin
                lane_px[c][k] = r_win[k][(2-c)*8 +: 8];
            end
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_lane
        icf_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_px   (lane_px[c]),
            .i_kern (r_s2_kern),
            .o_q    (lane_q[c])
        );
    end

    assign p_pix = r_s3_pass ? r_s3_pix : {lane_q[0], lane_q[1], lane_q[2]};

    // output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_ov && !o_pix.ready) begin
            if (r_s3_vld && en) begin
                r_sv <= 1'b1;
            end
        end else if (r_sv) begin
            r_ov <= 1'b1;
            r_sv <= 1'b0;
        end else begin
            r_ov <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_ov && !o_pix.ready) begin
            if (r_s3_vld && en) begin
                r_sk_pix  <= p_pix;
                r_sk_last <= r_s3_last;
            end
        end else if (r_sv) begin
            r_o_pix  <= r_sk_pix;
            r_o_last <= r_sk_last;
        end else begin
            r_o_pix  <= p_pix;
            r_o_last <= r_s3_last;
        end
    end

    assign o_pix.valid      = r_ov;
    assign o_pix.red_out    = r_o_pix[23:16];
    assign o_pix.green_out  = r_o_pix[15:8];
    assign o_pix.blue_out   = r_o_pix[7:0];
    assign o_pix.frame_last = r_o_last;

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_pend) <= 32'(w) + 32'd1)
        else $error("pending count above width+1");

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid entry held without output entry");

    a_empty_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && !i_cfg_we && i_pix.kind == KIND_DRAIN && r_pend == '0) |=> !r_s1.emit)
        else $error("drain with nothing pending produced a result");

    a_last_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && !i_cfg_we && s0_emit && is_last) |=> (r_out_col == '0 && r_out_row == 16'd0))
        else $error("output position did not wrap after last pixel");
endmodule
